// ----- rtl/core/bba_pkg.sv -----
// shared types and codes for the buddy block allocator
`default_nettype none

package bba_pkg;

   // widths of the fixed fields
   localparam int FREE_W  = 17;
   localparam int ARENA_W = 17;
   localparam int ADDR_W  = 32;
   localparam int SIZE_W  = 16;

   // action codes
   localparam logic [1:0] ACT_INIT    = 2'd0;
   localparam logic [1:0] ACT_ALLOC   = 2'd1;
   localparam logic [1:0] ACT_RELEASE = 2'd2;

   // status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_TOO_LARGE = 2'd1;
   localparam logic [1:0] STAT_NO_BLOCK  = 2'd2;

   // write enables of the slot header memories
   typedef struct packed {
      logic prev;
      logic next;
      logic order;
      logic free;
   } slot_we_type;

endpackage

`default_nettype wire

// ----- rtl/core/buddy_block_allocator_core.sv -----
// buddy allocator top level: register port and sequencer
// init carves blocks while stepping down the orders; allocate steps up the orders, searches the lists and splits;
// release frees the block and merges it with its buddy while the buddy header check passes
// throughput: one transaction at a time, busy high until the result strobe has gone;
// one sequencer, slot memories with one write and one registered read port each
// reset: synchronous, lists empty, free count zero, region base 0, arena size 65536
`default_nettype none

module buddy_block_allocator_core #(
   parameter int ORDER_COUNT  = 16,
   parameter int HEADER_BYTES = 16,
   parameter int REGION_BYTES = 65536
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_action,
   input  wire logic [bba_pkg::SIZE_W-1:0]    req_request_size,
   input  wire logic [bba_pkg::ADDR_W-1:0]    req_release_address,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic [bba_pkg::ADDR_W-1:0]         rsp_alloc_address,
   output logic [bba_pkg::FREE_W-1:0]         rsp_free_bytes,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [2:0]                    paddr,
   input  wire logic [31:0]                   pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   localparam logic REG_REGION_BASE = 1'b0;
   localparam logic REG_ARENA_SIZE  = 1'b1;

   logic [31:0]                  base_ff;
   logic [bba_pkg::ARENA_W-1:0]  arena_ff;
   logic                         wr_en;
   logic                         reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         arena_ff <= bba_pkg::ARENA_W'(65536);
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_REGION_BASE: base_ff  <= pwdata;
            REG_ARENA_SIZE:  arena_ff <= pwdata[bba_pkg::ARENA_W-1:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (reg_idx)
         REG_REGION_BASE: prdata = base_ff;
         REG_ARENA_SIZE:  prdata = 32'(arena_ff);
         default:         prdata = '0;
      endcase
   end

   bba_seq #(
      .ORDER_COUNT (ORDER_COUNT),
      .HEADER_BYTES(HEADER_BYTES),
      .REGION_BYTES(REGION_BYTES)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .action         (req_action),
      .request_size   (req_request_size),
      .release_address(req_release_address),
      .region_base    (base_ff),
      .arena_size     (arena_ff),
      .done           (rsp_valid),
      .status         (rsp_status),
      .alloc_address  (rsp_alloc_address),
      .free_bytes     (rsp_free_bytes)
   );

endmodule

`default_nettype wire

// ----- rtl/core/bba_slot_mem.sv -----
// slot header memories: prev link, next link, order and free flag per slot
`default_nettype none

module bba_slot_mem #(
   parameter int DEPTH = 4096,
   parameter int SW    = 12,
   parameter int PW    = 13,
   parameter int OW    = 4
) (
   input  wire logic                 clock,
   input  wire bba_pkg::slot_we_type wr_en,
   input  wire logic [SW-1:0]        prev_waddr,
   input  wire logic [PW-1:0]        prev_wdata,
   input  wire logic [SW-1:0]        next_waddr,
   input  wire logic [PW-1:0]        next_wdata,
   input  wire logic [SW-1:0]        order_waddr,
   input  wire logic [OW-1:0]        order_wdata,
   input  wire logic [SW-1:0]        free_waddr,
   input  wire logic                 free_wdata,
   input  wire logic [SW-1:0]        rd_addr,
   output logic [PW-1:0]             rd_prev,
   output logic [PW-1:0]             rd_next,
   output logic [OW-1:0]             rd_order,
   output logic                      rd_free
);

   logic [PW-1:0] prev_mem  [DEPTH];
   logic [PW-1:0] next_mem  [DEPTH];
   logic [OW-1:0] order_mem [DEPTH];
   logic          free_mem  [DEPTH];

   // writes, one port per array
   always_ff @(posedge clock) begin
      if (wr_en.prev) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
      if (wr_en.next) begin
         next_mem[next_waddr] <= next_wdata;
      end
      if (wr_en.order) begin
         order_mem[order_waddr] <= order_wdata;
      end
      if (wr_en.free) begin
         free_mem[free_waddr] <= free_wdata;
      end
   end

   // registered read at one shared address
   always_ff @(posedge clock) begin
      rd_prev  <= prev_mem[rd_addr];
      rd_next  <= next_mem[rd_addr];
      rd_order <= order_mem[rd_addr];
      rd_free  <= free_mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/core/bba_seq.sv -----
// sequencer: list heads, free byte count and the init, allocate and release walks
`default_nettype none

module bba_seq #(
   parameter int ORDER_COUNT  = 16,
   parameter int HEADER_BYTES = 16,
   parameter int REGION_BYTES = 65536
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    action,
   input  wire logic [bba_pkg::SIZE_W-1:0]    request_size,
   input  wire logic [bba_pkg::ADDR_W-1:0]    release_address,
   input  wire logic [bba_pkg::ADDR_W-1:0]    region_base,
   input  wire logic [bba_pkg::ARENA_W-1:0]   arena_size,
   output logic                               done,
   output logic [1:0]                         status,
   output logic [bba_pkg::ADDR_W-1:0]         alloc_address,
   output logic [bba_pkg::FREE_W-1:0]         free_bytes
);

   localparam int MIN_BLOCK  = (HEADER_BYTES <= 4) ? 4 : (HEADER_BYTES <= 8) ? 8 :
                               (HEADER_BYTES <= 16) ? 16 : 32;
   localparam int MIN_LOG    = $clog2(MIN_BLOCK);
   localparam int SLOT_COUNT = REGION_BYTES / MIN_BLOCK;
   localparam int SW         = $clog2(SLOT_COUNT);
   localparam int PW         = $clog2(SLOT_COUNT + 1);
   localparam int OW         = $clog2(ORDER_COUNT);
   localparam int OCW        = $clog2(ORDER_COUNT + 1);
   localparam int OFF_W      = $clog2(REGION_BYTES + 1);
   localparam int T1         = (ORDER_COUNT > OFF_W) ? ORDER_COUNT : OFF_W;
   localparam int CW         = ((T1 > 17) ? T1 : 17) + 1;
   localparam int LW         = (OFF_W > bba_pkg::ARENA_W) ? OFF_W : bba_pkg::ARENA_W;
   localparam int FW         = bba_pkg::FREE_W;
   localparam int AW         = bba_pkg::ADDR_W;

   localparam logic [PW-1:0]  NIL      = PW'(SLOT_COUNT);
   localparam logic [CW-1:0]  SLOTS_C  = CW'(SLOT_COUNT);
   localparam logic [OCW-1:0] OC_C     = OCW'(ORDER_COUNT);
   localparam logic [CW-1:0]  HDR_C    = CW'(HEADER_BYTES);
   localparam logic [FW-1:0]  HDR_F    = FW'(HEADER_BYTES);

   // sequencer states
   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_INIT  = 5'd1;
   localparam logic [4:0] S_ORD   = 5'd2;
   localparam logic [4:0] S_SRCH  = 5'd3;
   localparam logic [4:0] S_SPLIT = 5'd4;
   localparam logic [4:0] S_SPL1  = 5'd5;
   localparam logic [4:0] S_SPL2  = 5'd6;
   localparam logic [4:0] S_SPL3  = 5'd7;
   localparam logic [4:0] S_FIN   = 5'd8;
   localparam logic [4:0] S_REL0  = 5'd9;
   localparam logic [4:0] S_REL1  = 5'd10;
   localparam logic [4:0] S_MCHK  = 5'd11;
   localparam logic [4:0] S_MRD   = 5'd12;
   localparam logic [4:0] S_MRM2  = 5'd13;
   localparam logic [4:0] S_MUP   = 5'd14;
   localparam logic [4:0] S_PU1   = 5'd15;
   localparam logic [4:0] S_PU2   = 5'd16;
   localparam logic [4:0] S_RM1   = 5'd17;
   localparam logic [4:0] S_RM2   = 5'd18;
   localparam logic [4:0] S_DONE  = 5'd19;

   logic [4:0]       state_ff, state_in;
   logic [4:0]       ret_ff, ret_in;
   logic [PW-1:0]    heads_ff [ORDER_COUNT];
   logic [PW-1:0]    heads_in [ORDER_COUNT];
   logic [FW-1:0]    fbc_ff, fbc_in;
   logic [OCW-1:0]   o_ff, o_in;
   logic [OCW-1:0]   i_ff, i_in;
   logic [SW-1:0]    b_ff, b_in;
   logic [SW-1:0]    c_ff, c_in;
   logic [OW-1:0]    po_ff, po_in;
   logic [SW-1:0]    ps_ff, ps_in;
   logic [PW-1:0]    ph_ff, ph_in;
   logic [OFF_W-1:0] left_ff, left_in;
   logic [OFF_W-1:0] off_ff, off_in;
   logic [CW-1:0]    need_ff, need_in;
   logic [AW-1:0]    rel_ff, rel_in;
   logic [1:0]       status_ff, status_in;
   logic [AW-1:0]    addr_ff, addr_in;

   // memory ports
   bba_pkg::slot_we_type we;
   logic [SW-1:0]    prev_waddr, next_waddr, order_waddr, free_waddr, rd_addr;
   logic [PW-1:0]    prev_wdata, next_wdata;
   logic [OW-1:0]    order_wdata;
   logic             free_wdata;
   logic [PW-1:0]    rd_prev, rd_next;
   logic [OW-1:0]    rd_order;
   logic             rd_free;

   // shared working values
   logic [OW-1:0]    hd_idx;
   logic [PW-1:0]    hd_val;
   logic [LW-1:0]    limit_w;
   logic [OFF_W-1:0] limit;
   logic [CW-1:0]    bs;
   logic [CW-1:0]    slot_full;
   logic [CW-1:0]    boff;
   logic [AW-1:0]    off32;
   logic [OCW-1:0]   ni;

   bba_slot_mem #(
      .DEPTH(SLOT_COUNT),
      .SW   (SW),
      .PW   (PW),
      .OW   (OW)
   ) u_mem (
      .clock      (clock),
      .wr_en      (we),
      .prev_waddr (prev_waddr),
      .prev_wdata (prev_wdata),
      .next_waddr (next_waddr),
      .next_wdata (next_wdata),
      .order_waddr(order_waddr),
      .order_wdata(order_wdata),
      .free_waddr (free_waddr),
      .free_wdata (free_wdata),
      .rd_addr    (rd_addr),
      .rd_prev    (rd_prev),
      .rd_next    (rd_next),
      .rd_order   (rd_order),
      .rd_free    (rd_free)
   );

   // arena limit clamped to the region
   assign limit_w = (LW'(arena_size) > LW'(REGION_BYTES)) ? LW'(REGION_BYTES)
                                                          : LW'(arena_size);
   assign limit   = limit_w[OFF_W-1:0];

   // head read port: push reads the target list, search and split read list i
   assign hd_idx = (state_ff == S_PU1) ? po_ff : i_ff[OW-1:0];
   assign hd_val = heads_ff[hd_idx];

   assign ni = i_ff - OCW'(1);

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      heads_in  = heads_ff;
      fbc_in    = fbc_ff;
      o_in      = o_ff;
      i_in      = i_ff;
      b_in      = b_ff;
      c_in      = c_ff;
      po_in     = po_ff;
      ps_in     = ps_ff;
      ph_in     = ph_ff;
      left_in   = left_ff;
      off_in    = off_ff;
      need_in   = need_ff;
      rel_in    = rel_ff;
      status_in = status_ff;
      addr_in   = addr_ff;

      we          = '0;
      prev_waddr  = ps_ff;
      prev_wdata  = NIL;
      next_waddr  = ps_ff;
      next_wdata  = NIL;
      order_waddr = b_ff;
      order_wdata = o_ff[OW-1:0];
      free_waddr  = b_ff;
      free_wdata  = 1'b1;
      rd_addr     = ps_ff;

      bs        = CW'(1) << o_ff;
      slot_full = '0;
      boff      = '0;
      off32     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               status_in = bba_pkg::STAT_OK;
               addr_in   = '0;
               rel_in    = release_address;
               unique case (action)
                  bba_pkg::ACT_INIT: begin
                     for (int k = 0; k < ORDER_COUNT; k++) begin
                        heads_in[k] = NIL;
                     end
                     fbc_in   = '0;
                     o_in     = OCW'(ORDER_COUNT - 1);
                     left_in  = limit;
                     off_in   = '0;
                     state_in = S_INIT;
                  end
                  bba_pkg::ACT_ALLOC: begin
                     need_in = CW'(request_size) + HDR_C;
                     o_in    = OCW'(1);
                     if ((CW'(request_size) >> (ORDER_COUNT - 1)) != '0) begin
                        status_in = bba_pkg::STAT_TOO_LARGE;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_ORD;
                     end
                  end
                  bba_pkg::ACT_RELEASE: begin
                     state_in = (release_address == '0) ? S_DONE : S_REL0;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         // greedy carve, one candidate order or one block per pass
         S_INIT: begin
            slot_full = CW'(off_ff) >> MIN_LOG;
            if (bs < HDR_C) begin
               state_in = S_DONE;
            end else if (bs > CW'(left_ff)) begin
               if (o_ff == '0) begin
                  state_in = S_DONE;
               end else begin
                  o_in = o_ff - OCW'(1);
               end
            end else if (slot_full >= SLOTS_C) begin
               state_in = S_DONE;
            end else begin
               we.free     = 1'b1;
               free_waddr  = slot_full[SW-1:0];
               free_wdata  = 1'b1;
               we.order    = 1'b1;
               order_waddr = slot_full[SW-1:0];
               order_wdata = o_ff[OW-1:0];
               fbc_in      = fbc_ff + FW'(bs) - HDR_F;
               left_in     = left_ff - OFF_W'(bs);
               off_in      = off_ff + OFF_W'(bs);
               po_in       = o_ff[OW-1:0];
               ps_in       = slot_full[SW-1:0];
               ret_in      = S_INIT;
               state_in    = S_PU1;
            end
         end

         // smallest order holding size plus header
         S_ORD: begin
            if (o_ff >= OC_C) begin
               status_in = bba_pkg::STAT_TOO_LARGE;
               state_in  = S_DONE;
            end else if (bs < need_ff) begin
               o_in = o_ff + OCW'(1);
            end else begin
               i_in     = o_ff;
               state_in = S_SRCH;
            end
         end

         // first non-empty list at or above it
         S_SRCH: begin
            if (i_ff >= OC_C) begin
               status_in = bba_pkg::STAT_NO_BLOCK;
               state_in  = S_DONE;
            end else if (hd_val < NIL) begin
               state_in = S_SPLIT;
            end else begin
               i_in = i_ff + OCW'(1);
            end
         end

         // split down, or take the head once at the target order
         S_SPLIT: begin
            b_in  = hd_val[SW-1:0];
            po_in = i_ff[OW-1:0];
            ps_in = hd_val[SW-1:0];
            if (i_ff > o_ff) begin
               ret_in = S_SPL1;
            end else begin
               ret_in = S_FIN;
            end
            state_in = S_RM1;
         end

         S_SPL1: begin
            slot_full = CW'(b_ff) + ((CW'(1) << ni) >> MIN_LOG);
            if (slot_full >= SLOTS_C) begin
               slot_full = CW'(b_ff);
            end
            i_in        = ni;
            c_in        = slot_full[SW-1:0];
            we.free     = 1'b1;
            free_waddr  = slot_full[SW-1:0];
            free_wdata  = 1'b1;
            we.order    = 1'b1;
            order_waddr = slot_full[SW-1:0];
            order_wdata = ni[OW-1:0];
            state_in    = S_SPL2;
         end

         S_SPL2: begin
            we.order    = 1'b1;
            order_waddr = b_ff;
            order_wdata = i_ff[OW-1:0];
            po_in       = i_ff[OW-1:0];
            ps_in       = b_ff;
            ret_in      = S_SPL3;
            state_in    = S_PU1;
         end

         S_SPL3: begin
            fbc_in   = fbc_ff - HDR_F;
            po_in    = i_ff[OW-1:0];
            ps_in    = c_ff;
            ret_in   = S_SPLIT;
            state_in = S_PU1;
         end

         S_FIN: begin
            we.free    = 1'b1;
            free_waddr = b_ff;
            free_wdata = 1'b0;
            fbc_in     = fbc_ff - (FW'(bs) - HDR_F);
            addr_in    = region_base + (AW'(b_ff) << MIN_LOG) + AW'(HEADER_BYTES);
            state_in   = S_DONE;
         end

         // release: check the address and read the block header
         S_REL0: begin
            off32     = rel_ff - AW'(HEADER_BYTES) - region_base;
            slot_full = CW'(off32[OFF_W-1:0]) >> MIN_LOG;
            rd_addr   = slot_full[SW-1:0];
            b_in      = slot_full[SW-1:0];
            if ((off32 >= AW'(REGION_BYTES)) || (off32[MIN_LOG-1:0] != '0) ||
                (slot_full >= SLOTS_C)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_REL1;
            end
         end

         S_REL1: begin
            if (OCW'(rd_order) >= OC_C) begin
               state_in = S_DONE;
            end else begin
               o_in       = OCW'(rd_order);
               we.free    = 1'b1;
               free_waddr = b_ff;
               free_wdata = 1'b1;
               fbc_in     = fbc_ff + FW'(CW'(1) << rd_order) - HDR_F;
               po_in      = rd_order;
               ps_in      = b_ff;
               ret_in     = S_MCHK;
               state_in   = S_PU1;
            end
         end

         // buddy lookup inside the arena
         S_MCHK: begin
            boff      = (CW'(b_ff) << MIN_LOG) ^ (CW'(1) << o_ff);
            slot_full = boff >> MIN_LOG;
            rd_addr   = slot_full[SW-1:0];
            c_in      = slot_full[SW-1:0];
            if ((o_ff + OCW'(1)) >= OC_C) begin
               state_in = S_DONE;
            end else if ((boff + HDR_C) > CW'(limit)) begin
               state_in = S_DONE;
            end else if (slot_full >= SLOTS_C) begin
               state_in = S_DONE;
            end else begin
               state_in = S_MRD;
            end
         end

         S_MRD: begin
            if (!rd_free || (OCW'(rd_order) != o_ff)) begin
               state_in = S_DONE;
            end else begin
               if (b_ff > c_ff) begin
                  b_in = c_ff;
                  c_in = b_ff;
                  ps_in = c_ff;
               end else begin
                  ps_in = b_ff;
               end
               po_in    = o_ff[OW-1:0];
               ret_in   = S_MRM2;
               state_in = S_RM1;
            end
         end

         S_MRM2: begin
            po_in    = o_ff[OW-1:0];
            ps_in    = c_ff;
            ret_in   = S_MUP;
            state_in = S_RM1;
         end

         S_MUP: begin
            o_in        = o_ff + OCW'(1);
            we.order    = 1'b1;
            order_waddr = b_ff;
            order_wdata = o_in[OW-1:0];
            fbc_in      = fbc_ff + HDR_F;
            po_in       = o_in[OW-1:0];
            ps_in       = b_ff;
            ret_in      = S_MCHK;
            state_in    = S_PU1;
         end

         // push: link in front of the head
         S_PU1: begin
            ph_in           = hd_val;
            we.next         = 1'b1;
            next_waddr      = ps_ff;
            next_wdata      = hd_val;
            we.prev         = 1'b1;
            prev_waddr      = ps_ff;
            prev_wdata      = NIL;
            heads_in[po_ff] = PW'(ps_ff);
            state_in        = S_PU2;
         end

         S_PU2: begin
            if (ph_ff < NIL) begin
               we.prev    = 1'b1;
               prev_waddr = ph_ff[SW-1:0];
               prev_wdata = PW'(ps_ff);
            end
            state_in = ret_ff;
         end

         // remove: read the links, then patch neighbours
         S_RM1: begin
            rd_addr  = ps_ff;
            state_in = S_RM2;
         end

         S_RM2: begin
            if (rd_next < NIL) begin
               we.prev    = 1'b1;
               prev_waddr = rd_next[SW-1:0];
               prev_wdata = rd_prev;
            end
            if (rd_prev < NIL) begin
               we.next    = 1'b1;
               next_waddr = rd_prev[SW-1:0];
               next_wdata = rd_next;
            end else begin
               heads_in[po_ff] = rd_next;
            end
            state_in = ret_ff;
         end

         S_DONE: begin
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         fbc_ff   <= '0;
         for (int k = 0; k < ORDER_COUNT; k++) begin
            heads_ff[k] <= NIL;
         end
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         fbc_ff   <= fbc_in;
         heads_ff <= heads_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      o_ff      <= o_in;
      i_ff      <= i_in;
      b_ff      <= b_in;
      c_ff      <= c_in;
      po_ff     <= po_in;
      ps_ff     <= ps_in;
      ph_ff     <= ph_in;
      left_ff   <= left_in;
      off_ff    <= off_in;
      need_ff   <= need_in;
      rel_ff    <= rel_in;
      status_ff <= status_in;
      addr_ff   <= addr_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign done          = (state_ff == S_DONE);
   assign status        = status_ff;
   assign alloc_address = addr_ff;
   assign free_bytes    = fbc_ff;

endmodule

`default_nettype wire
